// ===== rtl/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the integer to decimal text core
// Widths, character codes, controller state and the command and status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Width of the signed input value (8 to 64).
  localparam int VALUE_BITS = 32;

  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
  localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

  localparam int IDX_W = $clog2(DIGITS);
  localparam int CNT_W = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIGN,
    ST_DIGIT
  } itda_state_t;

  typedef struct packed {
    logic load;        // take a new value
    logic shift;       // one double-dabble step
    logic latch_idx;   // capture index of leading digit
    logic emit_sign;   // put '-' in the output register
    logic emit_digit;  // put current digit in the output register
  } itda_cmd_t;

  typedef struct packed {
    logic neg;         // value being converted is negative
    logic shift_done;  // current shift is the last one
    logic idx_zero;    // current digit is the least significant
    logic out_free;    // output register can take a beat this cycle
  } itda_sts_t;

endpackage

// ===== rtl/itda_ctrl.sv =====
// ----------------------------------------------------------------------------
// itda_ctrl: sequencing for the integer to decimal text core
// Load, shift through the conversion, find the leading digit, then emit the
// sign and digits one beat at a time.
// ----------------------------------------------------------------------------
module itda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                value_valid,
  output logic                value_stall,
  input  itda_pkg::itda_sts_t sts,
  output itda_pkg::itda_cmd_t cmd
);
  import itda_pkg::*;

  itda_state_t state;
  itda_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (value_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts.shift_done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        state_next = sts.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (sts.out_free) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts.out_free && sts.idx_zero) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // no beat is taken while reset is held
  always_comb begin
    cmd         = '0;
    value_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        value_stall = rst;
        cmd.load    = value_valid && !rst;
      end
      ST_CONVERT: cmd.shift      = 1'b1;
      ST_SCAN:    cmd.latch_idx  = 1'b1;
      ST_SIGN:    cmd.emit_sign  = sts.out_free;
      ST_DIGIT:   cmd.emit_digit = sts.out_free;
      default: ;
    endcase
  end

  // Conversion keeps shifting until the last step.
  a_convert_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONVERT && !sts.shift_done) |=> (state == ST_CONVERT))
    else $error("conversion left early");

  // A sign beat is always followed by digits, never a return to idle.
  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sign |=> (state == ST_DIGIT))
    else $error("sign not followed by digits");

endmodule

// ===== rtl/itda_dp.sv =====
// ----------------------------------------------------------------------------
// itda_dp: datapath for the integer to decimal text core
// Magnitude and BCD shift registers (double dabble), leading digit search,
// and the output register.
// ----------------------------------------------------------------------------
module itda_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [itda_pkg::VALUE_BITS-1:0] value,
  input  itda_pkg::itda_cmd_t                   cmd,
  output itda_pkg::itda_sts_t                   sts,
  output logic                                  char_valid,
  input  logic                                  char_stall,
  output logic [7:0]                            char_code,
  output logic                                  is_last
);
  import itda_pkg::*;

  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [3:0]            bcd [DIGITS];
  logic [3:0]            adj [DIGITS];
  logic [CNT_W-1:0]      shift_cnt;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      top_idx;

  assign value_u = value;

  // add 3 to any digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // highest non-zero digit; zero if all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) top_idx = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value_u[VALUE_BITS-1];
      mag <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
      for (int i = 0; i < DIGITS; i++) bcd[i] <= 4'd0;
    end else if (cmd.shift) begin
      mag    <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd[0] <= {adj[0][2:0], mag[VALUE_BITS-1]};
      for (int i = 1; i < DIGITS; i++) bcd[i] <= {adj[i][2:0], adj[i-1][3]};
    end
    if (cmd.latch_idx) begin
      idx <= top_idx;
    end else if (cmd.emit_digit) begin
      idx <= idx - IDX_W'(1);
    end
    if (cmd.emit_sign) begin
      char_code <= CHAR_MINUS;
      is_last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= CHAR_ZERO + {4'd0, bcd[idx]};
      is_last   <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_cnt  <= '0;
      char_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        shift_cnt <= '0;
      end else if (cmd.shift) begin
        shift_cnt <= shift_cnt + CNT_W'(1);
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  assign sts.neg        = neg;
  assign sts.shift_done = (shift_cnt == CNT_W'(VALUE_BITS - 1));
  assign sts.idx_zero   = (idx == '0);
  assign sts.out_free   = !char_valid || !char_stall;

  // A beat is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!char_valid || !char_stall))
    else $error("output beat overwritten");

  // The least significant digit closes the text.
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && idx == '0) |=> (char_valid && is_last))
    else $error("final digit without last flag");

endmodule

// ===== rtl/int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts one signed value per item to its decimal text, one character per
// output beat, most significant first, last character flagged.
// ----------------------------------------------------------------------------
// Each accepted value is turned into its decimal text: a '-' for negative
// values, then the digits with no leading zeros ("0" for zero), the most
// negative value giving its exact text. One character leaves per beat and
// is_last marks the final one. An item is loaded, then takes VALUE_BITS
// double-dabble shift steps (32 by default), a step to locate the leading
// digit and then one output beat per character, 1 to 11 characters. One
// value is in work at a time; the next is taken once the last character
// sits in the output register, even while it waits there.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   value_valid,
  output logic                                   value_stall,
  input  logic signed [itda_pkg::VALUE_BITS-1:0] value,
  // output channel
  output logic                                   char_valid,
  input  logic                                   char_stall,
  output logic [7:0]                             char_code,
  output logic                                   is_last
);
  import itda_pkg::*;

  itda_cmd_t cmd;  // controller to datapath
  itda_sts_t sts;  // datapath to controller

  // sequencer: idle, convert, scan, sign, digits
  itda_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // shift registers, digit search and output register
  itda_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .is_last    (is_last)
  );

endmodule
